### rtl/core/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Shared types, command codes, panel stream constants and the glyph ROM
// for the page framebuffer text renderer.
// ----------------------------------------------------------------------------
package pfb_pkg;

    // command kinds
    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_FILL  = 3'd1;
    localparam logic [2:0] KIND_PIXEL = 3'd2;
    localparam logic [2:0] KIND_GLYPH = 3'd3;
    localparam logic [2:0] KIND_FLUSH = 3'd4;

    // panel stream
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [7:0] CMD_NIBBLE   = 8'h0F;
    localparam logic [7:0] COL_OFFSET   = 8'h02;
    localparam logic [7:0] BYTE_ALL_ON  = 8'hFF;
    localparam logic [7:0] BYTE_ALL_OFF = 8'h00;
    localparam int         HEADER_LEN   = 3;

    // glyph geometry
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_STEPS = 2 * GLYPH_COLS;

    typedef logic [GLYPH_COLS-1:0][7:0] glyph_cols_t;

    typedef struct packed {
        logic        found;
        glyph_cols_t cols;
    } glyph_t;

    // write port of the framebuffer store
    typedef struct packed {
        logic       en;
        logic       merge;   // 1: read-modify-write with mask, 0: plain write
        logic       set;     // merge polarity: 1 OR in, 0 clear
        logic [7:0] data;
    } wr_op_t;

    function automatic glyph_cols_t pack_cols(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [7:0] c2, input logic [7:0] c3,
                                              input logic [7:0] c4);
        glyph_cols_t r;
        r = {c4, c3, c2, c1, c0};
        return r;
    endfunction

    function automatic glyph_t char_glyph(input logic [7:0] code);
        glyph_t     g;
        logic [7:0] up;
        up = code;
        if (code >= 8'h61 && code <= 8'h7A) begin
            up = code - 8'h20;
        end
        g.found = 1'b1;
        unique case (up)
            8'h20: g.cols = pack_cols(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            8'h30: g.cols = pack_cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            8'h31: g.cols = pack_cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            8'h32: g.cols = pack_cols(8'h62, 8'h51, 8'h49, 8'h49, 8'h46);
            8'h33: g.cols = pack_cols(8'h22, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h34: g.cols = pack_cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            8'h35: g.cols = pack_cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            8'h36: g.cols = pack_cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            8'h37: g.cols = pack_cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            8'h38: g.cols = pack_cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h39: g.cols = pack_cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            8'h3A: g.cols = pack_cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            8'h2E: g.cols = pack_cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            8'h2D: g.cols = pack_cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            8'h41: g.cols = pack_cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            8'h42: g.cols = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            8'h43: g.cols = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            8'h44: g.cols = pack_cols(8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h45: g.cols = pack_cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            8'h46: g.cols = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            8'h47: g.cols = pack_cols(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
            8'h48: g.cols = pack_cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            8'h49: g.cols = pack_cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            8'h4B: g.cols = pack_cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            8'h4C: g.cols = pack_cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            8'h4D: g.cols = pack_cols(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            8'h4E: g.cols = pack_cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            8'h4F: g.cols = pack_cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            8'h50: g.cols = pack_cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            8'h52: g.cols = pack_cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            8'h53: g.cols = pack_cols(8'h26, 8'h49, 8'h49, 8'h49, 8'h32);
            8'h54: g.cols = pack_cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            8'h55: g.cols = pack_cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            8'h56: g.cols = pack_cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            8'h57: g.cols = pack_cols(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
            8'h59: g.cols = pack_cols(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
            8'h25: g.cols = pack_cols(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
            default:
            begin
                g.found = 1'b0;
                g.cols  = '0;
            end
        endcase
        return g;
    endfunction

endpackage

### rtl/core/pfb_store.sv
// ----------------------------------------------------------------------------
// pfb_store
// Framebuffer byte memory with registered read and a write port that can
// merge a bit mask into the last word read.
// ----------------------------------------------------------------------------
module pfb_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  pfb_pkg::wr_op_t          wr_op,
    output logic [7:0]               rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;
    logic [7:0] wr_value;

    always_comb
    begin
        if (!wr_op.merge) begin
            wr_value = wr_op.data;
        end else if (wr_op.set) begin
            wr_value = rd_data_reg | wr_op.data;
        end else begin
            wr_value = rd_data_reg & ~wr_op.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_op.en) begin
            mem[wr_addr] <= wr_value;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/page_framebuffer_text_renderer_core.sv
// ----------------------------------------------------------------------------
// page_framebuffer_text_renderer_core
// Monochrome page framebuffer with pixel, glyph, clear/fill commands and a
// byte-at-a-time panel stream for flushing.
// ----------------------------------------------------------------------------
// Every accepted command (start high while busy is low) gives exactly one
// result word, shown for one cycle with done high; the receiver cannot stall
// it, so take it when done is seen. A flush command byte comes back the cycle
// after start and busy stays low; a flush data byte first needs one
// framebuffer read, with busy high in S_FLUSH. An unknown character also
// returns its result straight from idle. For set pixel and known glyphs one
// shared shift/clip unit walks 5 columns x 2 pages (one step for a pixel),
// each touched byte costing a read and a merge write. Clear and fill sweep
// the framebuffer one byte a cycle. After reset the same sweep clears the
// framebuffer (busy high, no result). The column offset register may be
// written whenever the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module page_framebuffer_text_renderer_core #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        kind,
    input  logic signed [8:0] pos_x,
    input  logic signed [7:0] pos_y,
    input  logic [7:0]        char_code,
    input  logic              pixel_on,
    output logic              done,
    output logic              stream_valid,
    output logic [7:0]        stream_byte,
    output logic              is_data,
    output logic              frame_last,
    output logic              glyph_found,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int PAGE_COUNT = PANEL_HEIGHT / 8;
    localparam int STORE_SIZE = PANEL_WIDTH * PAGE_COUNT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int POS_W      = $clog2(PANEL_WIDTH + pfb_pkg::HEADER_LEN);
    localparam int PAGE_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(PANEL_WIDTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(STORE_SIZE - 1);
    localparam logic [9:0]        X_LIMIT    = 10'(PANEL_WIDTH);
    localparam logic [4:0]        PAGE_LIMIT = 5'(PAGE_COUNT);
    localparam logic [POS_W-1:0]  POS_HDR    = POS_W'(pfb_pkg::HEADER_LEN);
    localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(PANEL_WIDTH + pfb_pkg::HEADER_LEN - 1);
    localparam logic [PAGE_W-1:0] PAGE_LAST  = PAGE_W'(PAGE_COUNT - 1);
    localparam logic [3:0]        STEP_LAST  = 4'(pfb_pkg::GLYPH_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SWEEP = 5'b00010,
        S_STEP  = 5'b00100,
        S_WRITE = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic [7:0]            fill_reg, fill_next;
    logic                  report_reg, report_next;
    logic [3:0]            step_reg, step_next;
    logic [3:0]            last_step_reg, last_step_next;
    logic [8:0]            pos_x_reg, pos_x_next;
    logic [7:0]            pos_y_reg, pos_y_next;
    pfb_pkg::glyph_cols_t  cols_reg, cols_next;
    logic                  set_reg, set_next;
    logic                  found_reg, found_next;
    logic [ADDR_W-1:0]     waddr_reg, waddr_next;
    logic [7:0]            wmask_reg, wmask_next;
    logic [PAGE_W-1:0]     flush_page_reg, flush_page_next;
    logic [POS_W-1:0]      flush_pos_reg, flush_pos_next;
    logic                  mode_reg;

    logic                  done_reg, done_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  data_reg, data_next;
    logic                  last_reg, last_next;
    logic                  gfound_reg, gfound_next;

    // store port
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    pfb_pkg::wr_op_t       wr_op;
    logic [7:0]            rd_data;

    // shared shift/clip unit for one glyph or pixel step
    logic [2:0]            col_idx;
    logic                  half;
    logic [7:0]            col_bits;
    logic [9:0]            x_sum;
    logic [5:0]            pg;
    logic [15:0]           shifted;
    logic [7:0]            step_mask;
    logic                  step_ok;
    logic [ADDR_W-1:0]     step_addr;

    logic [ADDR_W-1:0]     flush_addr;
    logic [7:0]            col_cmd;
    pfb_pkg::glyph_t       glyph;

    always_comb
    begin
        col_idx  = step_reg[3:1];
        half     = step_reg[0];
        col_bits = cols_reg[col_idx];
        x_sum    = {pos_x_reg[8], pos_x_reg} + {7'b0, col_idx};
        // page of the top edge is floor(y / 8); the second half spills below
        pg        = {pos_y_reg[7], pos_y_reg[7:3]} + {5'b0, half};
        shifted   = {8'h00, col_bits} << pos_y_reg[2:0];
        step_mask = half ? shifted[15:8] : shifted[7:0];
        step_ok   = !x_sum[9] && (x_sum < X_LIMIT)
                    && !pg[5] && (pg[4:0] < PAGE_LIMIT)
                    && (step_mask != 8'h00);
        step_addr = ADDR_W'(pg[4:0]) * ROW_STRIDE + ADDR_W'(x_sum[8:0]);
    end

    assign flush_addr = ADDR_W'(flush_page_reg) * ROW_STRIDE
                        + ADDR_W'(flush_pos_reg - POS_HDR);
    assign col_cmd    = mode_reg ? pfb_pkg::COL_OFFSET : 8'h00;
    assign glyph      = pfb_pkg::char_glyph(char_code);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        fill_next       = fill_reg;
        report_next     = report_reg;
        step_next       = step_reg;
        last_step_next  = last_step_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        cols_next       = cols_reg;
        set_next        = set_reg;
        found_next      = found_reg;
        waddr_next      = waddr_reg;
        wmask_next      = wmask_reg;
        flush_page_next = flush_page_reg;
        flush_pos_next  = flush_pos_reg;
        done_next       = 1'b0;
        valid_next      = valid_reg;
        byte_next       = byte_reg;
        data_next       = data_reg;
        last_next       = last_reg;
        gfound_next     = gfound_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_addr         = '0;
        wr_op           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    valid_next  = 1'b0;
                    byte_next   = 8'h00;
                    data_next   = 1'b0;
                    last_next   = 1'b0;
                    gfound_next = 1'b0;
                    pos_x_next  = pos_x;
                    pos_y_next  = pos_y;
                    step_next   = 4'd0;
                    unique case (kind)
                        pfb_pkg::KIND_CLEAR, pfb_pkg::KIND_FILL:
                        begin
                            fill_next   = (kind == pfb_pkg::KIND_FILL) ?
                                          pfb_pkg::BYTE_ALL_ON : pfb_pkg::BYTE_ALL_OFF;
                            cnt_next    = '0;
                            report_next = 1'b1;
                            state_next  = S_SWEEP;
                        end
                        pfb_pkg::KIND_PIXEL:
                        begin
                            cols_next      = pfb_pkg::pack_cols(8'h01, 8'h00, 8'h00,
                                                                8'h00, 8'h00);
                            last_step_next = 4'd0;
                            set_next       = pixel_on;
                            found_next     = 1'b0;
                            state_next     = S_STEP;
                        end
                        pfb_pkg::KIND_GLYPH:
                        begin
                            if (glyph.found) begin
                                cols_next      = glyph.cols;
                                last_step_next = STEP_LAST;
                                set_next       = 1'b1;
                                found_next     = 1'b1;
                                state_next     = S_STEP;
                            end else begin
                                done_next = 1'b1;
                            end
                        end
                        pfb_pkg::KIND_FLUSH:
                        begin
                            valid_next = 1'b1;
                            priority if (flush_pos_reg == POS_W'(0)) begin
                                byte_next = pfb_pkg::CMD_PAGE | {4'h0, 4'(flush_page_reg)};
                                done_next = 1'b1;
                            end else if (flush_pos_reg == POS_W'(1)) begin
                                byte_next = col_cmd & pfb_pkg::CMD_NIBBLE;
                                done_next = 1'b1;
                            end else if (flush_pos_reg == POS_W'(2)) begin
                                byte_next = pfb_pkg::CMD_COL_HIGH | {4'h0, col_cmd[7:4]};
                                done_next = 1'b1;
                            end else begin
                                data_next  = 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = flush_addr;
                                state_next = S_FLUSH;
                            end
                            if (flush_pos_reg == POS_LAST) begin
                                flush_pos_next = '0;
                                if (flush_page_reg == PAGE_LAST) begin
                                    flush_page_next = '0;
                                    last_next       = 1'b1;
                                end else begin
                                    flush_page_next = flush_page_reg + PAGE_W'(1);
                                end
                            end else begin
                                flush_pos_next = flush_pos_reg + POS_W'(1);
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                wr_addr = cnt_reg;
                wr_op   = '{en: 1'b1, merge: 1'b0, set: 1'b0, data: fill_reg};
                if (cnt_reg == ADDR_LAST) begin
                    done_next  = report_reg;
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_STEP:
            begin
                if (step_ok) begin
                    rd_en      = 1'b1;
                    rd_addr    = step_addr;
                    waddr_next = step_addr;
                    wmask_next = step_mask;
                    state_next = S_WRITE;
                end else if (step_reg == last_step_reg) begin
                    gfound_next = found_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            S_WRITE:
            begin
                wr_addr = waddr_reg;
                wr_op   = '{en: 1'b1, merge: 1'b1, set: set_reg, data: wmask_reg};
                if (step_reg == last_step_reg) begin
                    gfound_next = found_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = S_STEP;
                end
            end
            S_FLUSH:
            begin
                byte_next  = rd_data;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            // reset starts a silent clearing sweep
            state_reg      <= S_SWEEP;
            cnt_reg        <= '0;
            fill_reg       <= pfb_pkg::BYTE_ALL_OFF;
            report_reg     <= 1'b0;
            step_reg       <= 4'd0;
            last_step_reg  <= 4'd0;
            set_reg        <= 1'b0;
            found_reg      <= 1'b0;
            flush_page_reg <= '0;
            flush_pos_reg  <= '0;
            mode_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            fill_reg       <= fill_next;
            report_reg     <= report_next;
            step_reg       <= step_next;
            last_step_reg  <= last_step_next;
            set_reg        <= set_next;
            found_reg      <= found_next;
            flush_page_reg <= flush_page_next;
            flush_pos_reg  <= flush_pos_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        cols_reg   <= cols_next;
        waddr_reg  <= waddr_next;
        wmask_reg  <= wmask_next;
        valid_reg  <= valid_next;
        byte_reg   <= byte_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        gfound_reg <= gfound_next;
    end

    pfb_store #(
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_op   (wr_op),
        .rd_data (rd_data)
    );

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign stream_valid = valid_reg;
    assign stream_byte  = byte_reg;
    assign is_data      = data_reg;
    assign frame_last   = last_reg;
    assign glyph_found  = gfound_reg;

endmodule
